// ===== design/rmq_pkg.sv =====
// Shared types for the rotation-matrix-to-quaternion converter.
// No dependencies; imported by the front stage, the top level and the checker.
package rmq_pkg;

    // Root branch: which component carries the square root.
    typedef enum logic [1:0] {
        BR_W,
        BR_X,
        BR_Y,
        BR_Z
    } br_t;

endpackage

// ===== design/rmq_mat_if.sv =====
// Matrix input channel: valid/ready handshake plus nine Q-format entries.
// Standalone interface; used by the top level, the checker and the testbench.
interface rmq_mat_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

// ===== design/rmq_quat_if.sv =====
// Quaternion output channel: valid/ready handshake plus four components and a flag.
// Standalone interface; used by the top level, the checker and the testbench.
interface rmq_quat_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] qx;
    logic signed [DATA_WIDTH-1:0] qy;
    logic signed [DATA_WIDTH-1:0] qz;
    logic signed [DATA_WIDTH-1:0] qw;
    logic                         degenerate;

    modport source (output valid, qx, qy, qz, qw, degenerate, input ready);
    modport sink   (input valid, qx, qy, qz, qw, degenerate, output ready);
endinterface

// ===== design/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix to quaternion converter (four-branch root method).
// Depends on rmq_pkg, rmq_mat_if, rmq_quat_if, rmq_front, rmq_sqrt, rmq_div.
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-------------
//  mat     | in  | m00..m22, signed Q fixed point   | valid/ready
//  quat    | out | qx, qy, qz, qw, degenerate       | valid/ready
//
// One item per cycle while quat does not stall. Items pass through the front
// register, the square root pipeline (RW stages, two radicand bits each), the
// divider (NUMW stages, one quotient bit each) and the output register.
// Reset clears every stage's valid bit; payload registers are not reset.
// A stall on quat freezes the whole pipeline; mat.ready is low only while the
// output register holds an item that is not being taken.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic       clk,
    input  logic       rst_n,
    rmq_mat_if.sink    mat,
    rmq_quat_if.source quat
);
    import rmq_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int MWF  = (W > F) ? W : F;
    localparam int SAW  = MWF + 3;          // signed root argument width
    localparam int AW   = MWF + 2;          // positive root argument magnitude
    localparam int NW   = AW + F;           // radicand width
    localparam int NW2  = NW + (NW % 2);    // rounded up to even
    localparam int RW   = NW2 / 2;          // root width
    localparam int NUMW = W + 1 + F;        // scaled numerator width
    localparam int DW   = RW + 1;           // divisor (2R) width
    localparam int SW1  = 3 + 3 * (W + 1);  // br, degen, sums
    localparam int SW2  = 3 + (RW - 1) + 3; // br, degen, half root, signs

    localparam logic [NUMW-1:0] QHI = NUMW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [NUMW-1:0] QLO = NUMW'(64'd1 << (W - 1));
    localparam logic [W-1:0]    SHI = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]    SLO = {1'b1, {(W-1){1'b0}}};

    logic en;

    // front stage
    logic signed [8:0][W-1:0] m_in;
    logic                     f_valid;
    br_t                      f_br;
    logic                     f_degen;
    logic [NW2-1:0]           f_rad;
    logic signed [2:0][W:0]   f_s;

    // root stage
    logic [SW1-1:0]           r_side_in;
    logic                     r_valid;
    logic [RW-1:0]            r_root;
    logic [SW1-1:0]           r_side;
    logic signed [2:0][W:0]   r_s;
    logic [2:0]               r_sign;
    logic [2:0][NUMW-1:0]     r_num;

    // divider
    logic [SW2-1:0]           d_side_in;
    logic                     d_valid;
    logic [2:0][NUMW-1:0]     d_quo;
    logic [SW2-1:0]           d_side;
    br_t                      d_br;
    logic                     d_degen;
    logic [RW-2:0]            d_half;
    logic [2:0]               d_sign;

    // saturation and placement
    logic [2:0][W-1:0]        lane;
    logic [W-1:0]             half_sat;
    logic [W-1:0]             cx, cy, cz, cw;

    // output register
    logic                     o_valid_reg;
    logic [W-1:0]             qx_reg, qy_reg, qz_reg, qw_reg;
    logic                     degen_reg;

    assign en        = !o_valid_reg || quat.ready;
    assign mat.ready = en;

    assign m_in = {mat.m22, mat.m21, mat.m20, mat.m12, mat.m11, mat.m10,
                   mat.m02, mat.m01, mat.m00};

    rmq_front #(
        .W   (W),
        .F   (F),
        .SAW (SAW),
        .AW  (AW),
        .NW2 (NW2)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mat.valid),
        .m         (m_in),
        .out_valid (f_valid),
        .out_br    (f_br),
        .out_degen (f_degen),
        .out_rad   (f_rad),
        .out_s     (f_s)
    );

    assign r_side_in = {f_br, f_degen, f_s};

    rmq_sqrt #(
        .NW2 (NW2),
        .SW  (SW1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_rad    (f_rad),
        .in_side   (r_side_in),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // magnitudes of the lane sums, scaled by 2^F, go to the divider
    assign r_s = r_side[SW1-4:0];
    for (genvar j = 0; j < 3; j++) begin : g_mag
        logic [W:0] mag;
        assign r_sign[j] = r_s[j][W];
        assign mag       = r_sign[j] ? (W+1)'(-r_s[j]) : r_s[j];
        assign r_num[j]  = {mag, {F{1'b0}}};
    end

    assign d_side_in = {r_side[SW1-1 -: 3], r_root[RW-1:1], r_sign};

    rmq_div #(
        .NUMW (NUMW),
        .DW   (DW),
        .SW   (SW2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .in_num    (r_num),
        .in_den    ({r_root, 1'b0}),
        .in_side   (d_side_in),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    assign d_br    = br_t'(d_side[SW2-1 -: 2]);
    assign d_degen = d_side[SW2-3];
    assign d_half  = d_side[RW+1:3];
    assign d_sign  = d_side[2:0];

    // signed saturation of each quotient
    for (genvar j = 0; j < 3; j++) begin : g_sat
        always_comb
        begin
            if (d_sign[j])
                lane[j] = (d_quo[j] >= QLO) ? SLO : W'(-d_quo[j]);
            else
                lane[j] = (d_quo[j] > QHI) ? SHI : d_quo[j][W-1:0];
        end
    end

    assign half_sat = (NUMW'(d_half) > QHI) ? SHI : W'(NUMW'(d_half));

    // place the root component and the three lanes
    always_comb
    begin
        unique case (d_br)
            BR_W:
            begin
                cx = lane[0]; cy = lane[1]; cz = lane[2]; cw = half_sat;
            end
            BR_X:
            begin
                cx = half_sat; cy = lane[0]; cz = lane[1]; cw = lane[2];
            end
            BR_Y:
            begin
                cx = lane[0]; cy = half_sat; cz = lane[1]; cw = lane[2];
            end
            default:
            begin
                cx = lane[0]; cy = lane[1]; cz = half_sat; cw = lane[2];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg    <= d_degen ? '0 : cx;
            qy_reg    <= d_degen ? '0 : cy;
            qz_reg    <= d_degen ? '0 : cz;
            qw_reg    <= d_degen ? '0 : cw;
            degen_reg <= d_degen;
        end
    end

    assign quat.valid      = o_valid_reg;
    assign quat.qx         = qx_reg;
    assign quat.qy         = qy_reg;
    assign quat.qz         = qz_reg;
    assign quat.qw         = qw_reg;
    assign quat.degenerate = degen_reg;

    // a flagged item carries an all-zero quaternion
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        quat.valid && quat.degenerate |->
            quat.qx == 0 && quat.qy == 0 && quat.qz == 0 && quat.qw == 0)
        else $error("degenerate item with nonzero components");

    // the trace branch always has a positive root argument
    a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && f_br == BR_W |-> !f_degen)
        else $error("trace branch flagged degenerate");

    // a stall freezes the pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(f_valid) && $stable(r_valid) && $stable(d_valid))
        else $error("pipeline moved during stall");

    // input is taken exactly when the output side can advance
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        mat.ready == (!quat.valid || quat.ready))
        else $error("input ready out of step with output");
endmodule

// ===== design/rmq_front.sv =====
// Front stage: trace, branch choice, root argument and off-diagonal sums, registered.
// Depends on rmq_pkg.
module rmq_front #(
    parameter int W   = 16,
    parameter int F   = 14,
    parameter int SAW = 19,
    parameter int AW  = 18,
    parameter int NW2 = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [8:0][W-1:0]    m,
    output logic                        out_valid,
    output rmq_pkg::br_t                out_br,
    output logic                        out_degen,
    output logic [NW2-1:0]              out_rad,
    output logic signed [2:0][W:0]      out_s
);
    import rmq_pkg::*;

    localparam logic signed [SAW-1:0] ONE = SAW'(1) << F;

    logic signed [SAW-1:0] d [9];
    logic signed [SAW-1:0] t;
    logic signed [SAW-1:0] a;
    logic signed [SAW-1:0] s_yz;   // m12 - m21
    logic signed [SAW-1:0] s_zx;   // m20 - m02
    logic signed [SAW-1:0] s_xy;   // m01 - m10
    logic signed [SAW-1:0] p_xy;   // m01 + m10
    logic signed [SAW-1:0] p_xz;   // m02 + m20
    logic signed [SAW-1:0] p_yz;   // m12 + m21
    br_t                   br;
    logic                  degen;
    logic signed [2:0][W:0] s_sel;

    logic                   valid_reg;
    br_t                    br_reg;
    logic                   degen_reg;
    logic [NW2-1:0]         rad_reg;
    logic signed [2:0][W:0] s_reg;

    for (genvar i = 0; i < 9; i++) begin : g_ext
        assign d[i] = {{(SAW-W){m[i][W-1]}}, m[i]};
    end

    assign t    = d[0] + d[4] + d[8];
    assign s_yz = d[5] - d[7];
    assign s_zx = d[6] - d[2];
    assign s_xy = d[1] - d[3];
    assign p_xy = d[1] + d[3];
    assign p_xz = d[2] + d[6];
    assign p_yz = d[5] + d[7];

    always_comb
    begin
        priority if (t > 0)
        begin
            br = BR_W;
            a  = t + ONE;
        end
        else if (d[0] >= d[4] && d[0] >= d[8])
        begin
            br = BR_X;
            a  = ONE + d[0] - d[4] - d[8];
        end
        else if (d[4] > d[8])
        begin
            br = BR_Y;
            a  = ONE + d[4] - d[0] - d[8];
        end
        else
        begin
            br = BR_Z;
            a  = ONE + d[8] - d[0] - d[4];
        end
    end

    assign degen = (a <= 0);

    // Lanes fill the three non-root components in x, y, z, w order.
    always_comb
    begin
        unique case (br)
            BR_W:
            begin
                s_sel[0] = s_yz[W:0];
                s_sel[1] = s_zx[W:0];
                s_sel[2] = s_xy[W:0];
            end
            BR_X:
            begin
                s_sel[0] = p_xy[W:0];
                s_sel[1] = p_xz[W:0];
                s_sel[2] = s_yz[W:0];
            end
            BR_Y:
            begin
                s_sel[0] = p_xy[W:0];
                s_sel[1] = p_yz[W:0];
                s_sel[2] = s_zx[W:0];
            end
            default:
            begin
                s_sel[0] = p_xz[W:0];
                s_sel[1] = p_yz[W:0];
                s_sel[2] = s_xy[W:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            br_reg    <= br;
            degen_reg <= degen;
            // degenerate items still run through the root with a harmless radicand
            rad_reg   <= degen ? NW2'(1) : NW2'({a[AW-1:0], {F{1'b0}}});
            s_reg     <= s_sel;
        end
    end

    assign out_valid = valid_reg;
    assign out_br    = br_reg;
    assign out_degen = degen_reg;
    assign out_rad   = rad_reg;
    assign out_s     = s_reg;
endmodule

// ===== design/rmq_sqrt.sv =====
// Pipelined integer square root, two radicand bits per stage, with pass-along side data.
// No dependencies.
module rmq_sqrt #(
    parameter int NW2 = 32,
    parameter int SW  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NW2-1:0]      in_rad,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic [NW2/2-1:0]    out_root,
    output logic [SW-1:0]       out_side
);
    localparam int RW  = NW2 / 2;
    localparam int RMW = RW + 2;

    logic [RW-1:0]  v_reg;
    logic [RW-1:0]  root_reg [RW];
    logic [RMW-1:0] rem_reg  [RW];
    logic [NW2-1:0] rad_reg  [RW];
    logic [SW-1:0]  side_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic           v_p;
        logic [RW-1:0]  root_p;
        logic [RMW-1:0] rem_p;
        logic [NW2-1:0] rad_p;
        logic [SW-1:0]  side_p;
        logic [RMW-1:0] cur;
        logic [RMW-1:0] trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign v_p    = in_valid;
            assign root_p = '0;
            assign rem_p  = '0;
            assign rad_p  = in_rad;
            assign side_p = in_side;
        end else begin : g_next
            assign v_p    = v_reg[k-1];
            assign root_p = root_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign rad_p  = rad_reg[k-1];
            assign side_p = side_reg[k-1];
        end

        assign cur   = {rem_p[RMW-3:0], rad_p[NW2-1 -: 2]};
        assign trial = {root_p, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_p[RW-2:0], ge};
                rem_reg[k]  <= ge ? (cur - trial) : cur;
                rad_reg[k]  <= {rad_p[NW2-3:0], 2'b00};
                side_reg[k] <= side_p;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];
endmodule

// ===== design/rmq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing one divisor.
// No dependencies.
module rmq_div #(
    parameter int NUMW = 31,
    parameter int DW   = 17,
    parameter int SW   = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][NUMW-1:0]    in_num,
    input  logic [DW-1:0]           in_den,
    input  logic [SW-1:0]           in_side,
    output logic                    out_valid,
    output logic [2:0][NUMW-1:0]    out_quo,
    output logic [SW-1:0]           out_side
);
    logic [NUMW-1:0]           v_reg;
    logic [DW-1:0]             den_reg [NUMW];
    logic [2:0][NUMW-1:0]      num_reg [NUMW];
    logic [2:0][DW-1:0]        rem_reg [NUMW];
    logic [2:0][NUMW-1:0]      quo_reg [NUMW];
    logic [SW-1:0]             side_reg[NUMW];

    for (genvar k = 0; k < NUMW; k++) begin : g_stage
        logic                 v_p;
        logic [DW-1:0]        den_p;
        logic [2:0][NUMW-1:0] num_p;
        logic [2:0][DW-1:0]   rem_p;
        logic [2:0][NUMW-1:0] quo_p;
        logic [SW-1:0]        side_p;
        logic [2:0][DW-1:0]   rem_n;
        logic [2:0]           bit_n;

        if (k == 0) begin : g_first
            assign v_p    = in_valid;
            assign den_p  = in_den;
            assign num_p  = in_num;
            assign rem_p  = '0;
            assign quo_p  = '0;
            assign side_p = in_side;
        end else begin : g_next
            assign v_p    = v_reg[k-1];
            assign den_p  = den_reg[k-1];
            assign num_p  = num_reg[k-1];
            assign rem_p  = rem_reg[k-1];
            assign quo_p  = quo_reg[k-1];
            assign side_p = side_reg[k-1];
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [DW:0] cur;
            assign cur      = {rem_p[j], num_p[j][NUMW-1]};
            assign bit_n[j] = (cur >= {1'b0, den_p});
            assign rem_n[j] = bit_n[j] ? DW'(cur - {1'b0, den_p}) : cur[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k]  <= den_p;
                side_reg[k] <= side_p;
                rem_reg[k]  <= rem_n;
                for (int j = 0; j < 3; j++)
                begin
                    num_reg[k][j] <= {num_p[j][NUMW-2:0], 1'b0};
                    quo_reg[k][j] <= {quo_p[j][NUMW-2:0], bit_n[j]};
                end
            end
        end
    end

    assign out_valid = v_reg[NUMW-1];
    assign out_quo   = quo_reg[NUMW-1];
    assign out_side  = side_reg[NUMW-1];
endmodule

// ===== verif/rmq_checker.sv =====
`timescale 1ns / 100ps
// Checker for the matrix-to-quaternion converter: watches both channels,
// predicts each quaternion and compares. Depends on rmq_pkg, rmq_mat_if, rmq_quat_if.
module rmq_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic clk,
    input  logic rst_n,
    rmq_mat_if   mat,
    rmq_quat_if  quat,
    output int   errors,
    output int   pending
);
    import rmq_pkg::*;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] qx;
        logic signed [DATA_WIDTH-1:0] qy;
        logic signed [DATA_WIDTH-1:0] qz;
        logic signed [DATA_WIDTH-1:0] qw;
        logic                         degenerate;
    } quat_t;

    quat_t quat_queue[$];

    localparam longint QMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
    localparam longint QMIN = -QMAX - 1;

    function automatic longint clamp_q(longint v);
        if (v > QMAX)
            return QMAX;
        if (v < QMIN)
            return QMIN;
        return v;
    endfunction

    function automatic longint int_root(longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // s * 2^F / (2r), truncated toward zero, then saturated
    function automatic longint scaled_div(longint s, longint r);
        longint mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = (mag <<< FRAC_BITS) / (2 * r);
        return clamp_q(s < 0 ? -q : q);
    endfunction

    function automatic quat_t convert(longint d[9]);
        quat_t  o;
        br_t    br;
        longint t;
        longint a;
        longint r;
        longint half;
        longint one;
        one = 64'sd1 <<< FRAC_BITS;
        o = '0;
        t = d[0] + d[4] + d[8];
        if (t > 0)
        begin
            br = BR_W;
            a = t + one;
        end
        else if (d[0] >= d[4] && d[0] >= d[8])
        begin
            br = BR_X;
            a = one + d[0] - d[4] - d[8];
        end
        else if (d[4] > d[8])
        begin
            br = BR_Y;
            a = one + d[4] - d[0] - d[8];
        end
        else
        begin
            br = BR_Z;
            a = one + d[8] - d[0] - d[4];
        end
        if (a <= 0)
        begin
            o.degenerate = 1'b1;
            return o;
        end
        r = int_root(a <<< FRAC_BITS);
        half = clamp_q(r >>> 1);
        case (br)
            BR_W:
            begin
                o.qw = half;
                o.qx = scaled_div(d[5] - d[7], r);
                o.qy = scaled_div(d[6] - d[2], r);
                o.qz = scaled_div(d[1] - d[3], r);
            end
            BR_X:
            begin
                o.qx = half;
                o.qy = scaled_div(d[1] + d[3], r);
                o.qz = scaled_div(d[2] + d[6], r);
                o.qw = scaled_div(d[5] - d[7], r);
            end
            BR_Y:
            begin
                o.qy = half;
                o.qx = scaled_div(d[3] + d[1], r);
                o.qz = scaled_div(d[7] + d[5], r);
                o.qw = scaled_div(d[6] - d[2], r);
            end
            default:
            begin
                o.qz = half;
                o.qx = scaled_div(d[6] + d[2], r);
                o.qy = scaled_div(d[7] + d[5], r);
                o.qw = scaled_div(d[1] - d[3], r);
            end
        endcase
        return o;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        longint d[9];
        quat_t  e;
        if (rst_n && mat.valid && mat.ready)
        begin
            d = '{mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
                  mat.m20, mat.m21, mat.m22};
            quat_queue.push_back(convert(d));
        end
        if (rst_n && quat.valid && quat.ready)
        begin
            if (quat_queue.size() == 0)
                report("unexpected item", 1, 0);
            else
            begin
                e = quat_queue.pop_front();
                if (quat.qx !== e.qx)
                    report("qx", quat.qx, e.qx);
                if (quat.qy !== e.qy)
                    report("qy", quat.qy, e.qy);
                if (quat.qz !== e.qz)
                    report("qz", quat.qz, e.qz);
                if (quat.qw !== e.qw)
                    report("qw", quat.qw, e.qw);
                if (quat.degenerate !== e.degenerate)
                    report("degenerate", quat.degenerate, e.degenerate);
            end
        end
        pending = quat_queue.size();
    end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the converter test: clock, reset, matrix stimulus, output stalls
// and verdict. Depends on rmq_pkg, both channel interfaces, the top level, rmq_checker.
module testbench;
    localparam int DW = 16;
    localparam int FB = 14;
    localparam int ONE = 1 << FB;
    localparam int RANDOM_ITEMS = 700;
    localparam int LATENCY = 60;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   calm;     // no idling on either side while set

    rmq_mat_if  #(.DATA_WIDTH(DW)) mat ();
    rmq_quat_if #(.DATA_WIDTH(DW)) quat ();

    rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .mat  (mat),
        .quat (quat)
    );

    rmq_checker #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) checker_i (
        .clk    (clk),
        .rst_n  (rst_n),
        .mat    (mat),
        .quat   (quat),
        .errors (errors),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Cycle watchdog: ends a hung run.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: stalls at random, with odds of 17 in a hundred, unless calm.
    initial
    begin
        quat.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            quat.ready <= calm || ($urandom_range(99) >= 17);
        end
    end

    // Sends one matrix; idles at random before it, holds until taken.
    task automatic send(logic [DW-1:0] m[9]);
        while (!calm && $urandom_range(99) < 17)
        begin
            mat.valid <= 1'b0;
            @(posedge clk);
        end
        mat.valid <= 1'b1;
        {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
         mat.m20, mat.m21, mat.m22} <= {m[0], m[1], m[2], m[3], m[4], m[5],
                                        m[6], m[7], m[8]};
        @(posedge clk);
        while (!mat.ready)
            @(posedge clk);
    endtask

    // Sends one matrix given as integers (directed cases).
    task automatic send_int(int a0, int a1, int a2, int a3, int a4, int a5,
                            int a6, int a7, int a8);
        logic [DW-1:0] m[9];
        m = '{a0[DW-1:0], a1[DW-1:0], a2[DW-1:0], a3[DW-1:0], a4[DW-1:0],
              a5[DW-1:0], a6[DW-1:0], a7[DW-1:0], a8[DW-1:0]};
        send(m);
    endtask

    // Random matrix: a near rotation (entries within +-ONE, branch chosen by
    // a dominant diagonal unless dom is 3) most of the time, full-range noise otherwise.
    task automatic send_random();
        logic [DW-1:0] m[9];
        int k;
        int dom;
        if ($urandom_range(99) < 30)
        begin
            for (k = 0; k < 9; k++)
                m[k] = $urandom();
        end
        else
        begin
            for (k = 0; k < 9; k++)
                m[k] = $urandom_range(2 * ONE) - ONE;
            dom = $urandom_range(3);
            if (dom < 3)
            begin
                m[4 * dom] = ONE - $urandom_range(ONE / 4);
                for (k = 0; k < 3; k++)
                    if (k != dom)
                        m[4 * k] = $urandom_range(ONE / 2) - ONE;
            end
        end
        send(m);
    endtask

    initial
    begin
        int i;
        calm = 1'b0;
        rst_n = 1'b0;
        mat.valid = 1'b0;
        {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12,
         mat.m20, mat.m21, mat.m22} = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity and the half-turns about each axis hit every branch.
        send_int(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_int(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
        send_int(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
        send_int(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE);
        // Quarter turn about z, with off-diagonal signs.
        send_int(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE);
        // Zero trace: the x branch wins an all-zero diagonal tie; the second case goes to z.
        send_int(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_int(-100, 0, 0, 0, -100, 0, 0, 0, 200);
        // Diagonal extremes of mixed sign.
        send_int(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767);
        send_int(-20000, 5, 5, 5, -20000, 5, 5, 5, 30000);
        // Negative trace, m11 and m22 tied: z branch.
        send_int(-ONE, 0, 0, 0, 0, 0, 0, 0, 0);
        // Smallest root, largest off-diagonal sums: both saturation limits.
        send_int(0, 32767, 32767, 32767, 0, 32767, 32767, -32768, 0);
        send_int(0, -32768, -32768, -32768, 0, -32768, -32768, 32767, 0);
        // Extremes of every field.
        send_int(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_int(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                 -32768, -32768);
        send_int(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
        send_int(-1, -1, -1, -1, -1, -1, -1, -1, -1);

        // Pause until every expected quaternion is back.
        mat.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 300 && i < 400);
            send_random();
        end
        calm = 1'b0;
        mat.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
design/rmq_pkg.sv
design/rmq_mat_if.sv
design/rmq_quat_if.sv
design/rmq_front.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
verif/rmq_checker.sv
verif/testbench.sv
